// ----- hw/rtl/ti_pkg.sv -----
// Shared types and constants for the triangle incenter pipeline.
package ti_pkg;

  // Width of the fixed-point result fields
  localparam int unsigned OUT_BITS = 24;

  // One result word as it sits in the output queue
  typedef struct packed {
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
    logic                deg;
  } ti_out_t;

endpackage

// ----- hw/rtl/triangle_incenter_top.sv -----
// Triangle incenter: side-length weighted mean of three vertices, fully pipelined.
//
// Input channel: in_valid_i / in_stall_o with the six vertex coordinates. A word is taken
// at a rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with center_x_o, center_y_o (signed, FRAC_BITS
// fractional bits) and degenerate_o, which is set when all three vertices coincide; the
// first vertex is then returned.
// Throughput: one word per cycle while the output queue is not full. Each word passes through
// the square-root pipeline (one root bit per stage) and then the divider pipeline (one
// quotient bit per stage) on its way from acceptance to out_valid_o.
// A two-word queue at the end holds results while the receiver stalls; the pipeline keeps
// moving, and the input takes words, until that queue is full. Then the whole pipeline
// holds, in_stall_o rises, and nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties every stage and the queue. The block keeps no
// state between words.
module triangle_incenter_top #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      ax_i,
  input  logic signed [COORD_BITS-1:0]      ay_i,
  input  logic signed [COORD_BITS-1:0]      bx_i,
  input  logic signed [COORD_BITS-1:0]      by_coord_i,
  input  logic signed [COORD_BITS-1:0]      cx_i,
  input  logic signed [COORD_BITS-1:0]      cy_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ti_pkg::OUT_BITS-1:0] center_x_o,
  output logic signed [ti_pkg::OUT_BITS-1:0] center_y_o,
  output logic                              degenerate_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned L   = C + F + 1;          // root width
  localparam int unsigned LS  = L + 2;              // length sum width
  localparam int unsigned QW  = C + F + 1;          // quotient width
  localparam int unsigned NW  = L + C + 2 + F;      // numerator width
  localparam int unsigned OB  = ti_pkg::OUT_BITS;
  localparam int unsigned SW  = ((QW + 1 > OB) ? QW + 1 : OB) + 1;

  // Pipeline advance, held only when the output queue is full
  logic [1:0] cnt_q;
  logic       en;
  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  // Stage 1: biased coordinates and absolute differences
  logic [5:0][C-1:0] s1_u_q, s1_d_q, u_in, d_in;
  logic              s1_v_q;

  always_comb begin
    u_in[0] = {~ax_i[C-1],       ax_i[C-2:0]};
    u_in[1] = {~ay_i[C-1],       ay_i[C-2:0]};
    u_in[2] = {~bx_i[C-1],       bx_i[C-2:0]};
    u_in[3] = {~by_coord_i[C-1], by_coord_i[C-2:0]};
    u_in[4] = {~cx_i[C-1],       cx_i[C-2:0]};
    u_in[5] = {~cy_i[C-1],       cy_i[C-2:0]};
    d_in[0] = (u_in[2] >= u_in[4]) ? u_in[2] - u_in[4] : u_in[4] - u_in[2];
    d_in[1] = (u_in[3] >= u_in[5]) ? u_in[3] - u_in[5] : u_in[5] - u_in[3];
    d_in[2] = (u_in[4] >= u_in[0]) ? u_in[4] - u_in[0] : u_in[0] - u_in[4];
    d_in[3] = (u_in[5] >= u_in[1]) ? u_in[5] - u_in[1] : u_in[1] - u_in[5];
    d_in[4] = (u_in[0] >= u_in[2]) ? u_in[0] - u_in[2] : u_in[2] - u_in[0];
    d_in[5] = (u_in[1] >= u_in[3]) ? u_in[1] - u_in[3] : u_in[3] - u_in[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_u_q <= u_in;
      s1_d_q <= d_in;
    end
  end

  // Stage 2: squares
  logic [5:0][C-1:0]   s2_u_q;
  logic [5:0][2*C-1:0] s2_sq_q;
  logic                s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_u_q <= s1_u_q;
      for (int j = 0; j < 6; j++) begin
        s2_sq_q[j] <= (2*C)'(s1_d_q[j]) * (2*C)'(s1_d_q[j]);
      end
    end
  end

  // Square-root pipeline, index 0 holds the radicands
  logic [L+1:0]      sq_rem_q  [L+1][3];
  logic [L-1:0]      sq_root_q [L+1][3];
  logic [2*L-1:0]    sq_rad_q  [L+1][3];
  logic [5:0][C-1:0] sq_u_q    [L+1];
  logic [L:0]        sq_v_q;

  // Stage 3: sums of squares, scaled for the fractional root bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_u_q[0] <= s2_u_q;
      for (int j = 0; j < 3; j++) begin
        sq_rad_q[0][j]  <= ((2*L)'(s2_sq_q[2*j]) + (2*L)'(s2_sq_q[2*j+1])) << (2*F);
        sq_rem_q[0][j]  <= '0;
        sq_root_q[0][j] <= '0;
      end
    end
  end

  // One root bit per stage, restoring method
  for (genvar k = 0; k < L; k++) begin : g_sqrt
    localparam int unsigned PI = L - 1 - k;
    logic [L+1:0] rem_sh [3];
    logic [L+1:0] trial  [3];
    logic         take   [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        rem_sh[j] = {sq_rem_q[k][j][L-1:0], sq_rad_q[k][j][2*PI +: 2]};
        trial[j]  = {sq_root_q[k][j], 2'b01};
        take[j]   = (rem_sh[j] >= trial[j]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_u_q[k+1] <= sq_u_q[k];
        for (int j = 0; j < 3; j++) begin
          sq_rad_q[k+1][j]  <= sq_rad_q[k][j];
          sq_rem_q[k+1][j]  <= take[j] ? rem_sh[j] - trial[j] : rem_sh[j];
          sq_root_q[k+1][j] <= {sq_root_q[k][j][L-2:0], take[j]};
        end
      end
    end
  end

  // Products stage: length times vertex, length sum
  logic [5:0][L+C-1:0] sp_p_q;
  logic [LS-1:0]       sp_sum_q;
  logic [C-1:0]        sp_ua_q, sp_ya_q;
  logic                sp_v_q;
  logic [LS-1:0]       len_sum;

  assign len_sum = LS'(sq_root_q[L][0]) + LS'(sq_root_q[L][1]) + LS'(sq_root_q[L][2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_v_q <= 1'b0;
    end else if (en) begin
      sp_v_q <= sq_v_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sp_p_q[j]   <= (L+C)'(sq_root_q[L][j]) * (L+C)'(sq_u_q[L][2*j]);
        sp_p_q[j+3] <= (L+C)'(sq_root_q[L][j]) * (L+C)'(sq_u_q[L][2*j+1]);
      end
      sp_sum_q <= len_sum;
      sp_ua_q  <= sq_u_q[L][0];
      sp_ya_q  <= sq_u_q[L][1];
    end
  end

  // Divider pipeline, index 0 holds the rounded numerators
  logic [LS-1:0] dv_rem_q [QW+1][2];
  logic [QW-1:0] dv_nq_q  [QW+1][2];
  logic [LS-1:0] dv_d_q   [QW+1];
  logic          dv_deg_q [QW+1];
  logic [C-1:0]  dv_ua_q  [QW+1];
  logic [C-1:0]  dv_ya_q  [QW+1];
  logic [QW:0]   dv_v_q;
  logic [NW-1:0] num [2];

  always_comb begin
    num[0] = ((NW'(sp_p_q[0]) + NW'(sp_p_q[1]) + NW'(sp_p_q[2])) << F) + NW'(sp_sum_q >> 1);
    num[1] = ((NW'(sp_p_q[3]) + NW'(sp_p_q[4]) + NW'(sp_p_q[5])) << F) + NW'(sp_sum_q >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sp_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        dv_rem_q[0][j] <= LS'(num[j][NW-1:QW]);
        dv_nq_q[0][j]  <= num[j][QW-1:0];
      end
      dv_d_q[0]   <= sp_sum_q;
      dv_deg_q[0] <= (sp_sum_q == '0);
      dv_ua_q[0]  <= sp_ua_q;
      dv_ya_q[0]  <= sp_ya_q;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [LS:0] t  [2];
    logic        ge [2];

    always_comb begin
      for (int j = 0; j < 2; j++) begin
        t[j]  = {dv_rem_q[k][j], dv_nq_q[k][j][QW-1]};
        ge[j] = (t[j] >= {1'b0, dv_d_q[k]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int j = 0; j < 2; j++) begin
          dv_rem_q[k+1][j] <= ge[j] ? LS'(t[j] - {1'b0, dv_d_q[k]}) : t[j][LS-1:0];
          dv_nq_q[k+1][j]  <= {dv_nq_q[k][j][QW-2:0], ge[j]};
        end
        dv_d_q[k+1]   <= dv_d_q[k];
        dv_deg_q[k+1] <= dv_deg_q[k];
        dv_ua_q[k+1]  <= dv_ua_q[k];
        dv_ya_q[k+1]  <= dv_ya_q[k];
      end
    end
  end

  // Unbias and clamp to the output width
  logic [QW-1:0]        qx, qy;
  logic signed [SW-1:0] vx, vy;
  logic signed [SW-1:0] bias_s, hi_s, lo_s;
  ti_pkg::ti_out_t      w_item;

  always_comb begin
    bias_s = SW'(1) <<< (C - 1 + F);
    hi_s   = (SW'(1) <<< (OB - 1)) - SW'(1);
    lo_s   = -(SW'(1) <<< (OB - 1));
    qx = dv_deg_q[QW] ? (QW'(dv_ua_q[QW]) << F) : dv_nq_q[QW][0];
    qy = dv_deg_q[QW] ? (QW'(dv_ya_q[QW]) << F) : dv_nq_q[QW][1];
    vx = $signed(SW'(qx)) - bias_s;
    vy = $signed(SW'(qy)) - bias_s;
    if (vx > hi_s) vx = hi_s;
    if (vx < lo_s) vx = lo_s;
    if (vy > hi_s) vy = hi_s;
    if (vy < lo_s) vy = lo_s;
    w_item.x   = vx[OB-1:0];
    w_item.y   = vy[OB-1:0];
    w_item.deg = dv_deg_q[QW];
  end

  // Two-word output queue
  ti_pkg::ti_out_t e0_q, e1_q;
  logic            push, pop;

  assign pop  = (cnt_q != 2'd0) && !out_stall_i;
  assign push = en && dv_v_q[QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      e0_q <= (cnt_q == 2'd2) ? e1_q : w_item;
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        e0_q <= w_item;
      end else begin
        e1_q <= w_item;
      end
    end
  end

  assign out_valid_o  = (cnt_q != 2'd0);
  assign center_x_o   = e0_q.x;
  assign center_y_o   = e0_q.y;
  assign degenerate_o = e0_q.deg;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != 2'd2)) else $error("push into full output queue");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[L] |-> (sq_rem_q[L][0] <= {1'b0, sq_root_q[L][0], 1'b0}))
    else $error("square root remainder too large");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[QW] && !dv_deg_q[QW]) |-> (dv_rem_q[QW][0] < dv_d_q[QW]))
    else $error("divider remainder not below divisor");

endmodule
